>>> rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB duty converter.
// No dependencies; used by the converter and its checker.
package hsv2rgb_pkg;

  // Default fixed-point formats
  localparam int unsigned HUE_BITS_DEF  = 16;
  localparam int unsigned FRAC_BITS_DEF = 15;

  // Port field widths
  localparam int unsigned IN_W    = 16;
  localparam int unsigned SCALE_W = 7;
  localparam int unsigned DUTY_W  = 7;

  localparam logic [DUTY_W-1:0]  DUTY_MAX    = 7'd100;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd100;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_SCALE_RED   = 2'd0,
    REG_SCALE_GREEN = 2'd1,
    REG_SCALE_BLUE  = 2'd2
  } reg_idx_e;

  // Hue sector, 60 degrees each
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

endpackage

>>> rtl/hsv_to_rgb_duty_converter.sv
// HSV to RGB PWM duty converter, six-stage pipeline with APB scale registers.
// Depends on hsv2rgb_pkg.
//
// Takes one word per cycle (hue, saturation, value) and returns one word of
// red, green and blue duty percent, 0..100. The stages are:
// hue times six and saturation clamp, the two hue-fraction products, the
// p/q/t levels and sector select, value times level, times channel scale,
// then shift and clamp into the output register. The whole pipeline advances
// together: it takes a new word whenever the output register is empty or is
// being read, so with the output side always ready the rate is one word per
// cycle. Scale registers live at byte addresses 0, 4 and 8 (red, green,
// blue), reset to 100, and should be written only with the pipeline empty.
module hsv_to_rgb_duty_converter #(
  parameter int unsigned HUE_BITS  = hsv2rgb_pkg::HUE_BITS_DEF,
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // hue[15:0], saturation[31:16], brightness[47:32]
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // red_duty[6:0], green_duty[13:7], blue_duty[20:14]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW  = hsv2rgb_pkg::IN_W;
  localparam int unsigned SW  = hsv2rgb_pkg::SCALE_W;
  localparam int unsigned DW  = hsv2rgb_pkg::DUTY_W;
  localparam int unsigned HB  = HUE_BITS;
  localparam int unsigned FW  = FRAC_BITS + 1;          // level width, holds 1.0
  localparam int unsigned CW  = IW + FW;                // saturation compare width
  localparam int unsigned LW  = IW + FW;                // value * level
  localparam int unsigned PW  = LW + SW;                // value * level * scale
  localparam int unsigned EW  = 2 * FRAC_BITS + 24;     // room for shift and clamp
  localparam int unsigned NST = 6;

  localparam logic [FW-1:0] ONE_F  = FW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] ONE_C  = CW'(1) << FRAC_BITS;
  localparam logic [HB:0]   ONE_H  = (HB + 1)'(1) << HB;
  localparam logic [EW-1:0] MAX_E  = EW'(hsv2rgb_pkg::DUTY_MAX);

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [SW-1:0] scale_red_q, scale_green_q, scale_blue_q;
  logic          cfg_wr;
  hsv2rgb_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = hsv2rgb_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_red_q   <= hsv2rgb_pkg::SCALE_RESET;
      scale_green_q <= hsv2rgb_pkg::SCALE_RESET;
      scale_blue_q  <= hsv2rgb_pkg::SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hsv2rgb_pkg::REG_SCALE_RED:   scale_red_q   <= pwdata[SW-1:0];
        hsv2rgb_pkg::REG_SCALE_GREEN: scale_green_q <= pwdata[SW-1:0];
        hsv2rgb_pkg::REG_SCALE_BLUE:  scale_blue_q  <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_idx)
      hsv2rgb_pkg::REG_SCALE_RED:   prdata = 32'(scale_red_q);
      hsv2rgb_pkg::REG_SCALE_GREEN: prdata = 32'(scale_green_q);
      hsv2rgb_pkg::REG_SCALE_BLUE:  prdata = 32'(scale_blue_q);
      default:                      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Flow control: one enable for all stages
  logic           adv;
  logic [NST-1:0] vld_q;

  assign adv             = !vld_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid_i};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: hue wrap, hue * 6, saturation clamp
  logic [IW-1:0]     in_hue, in_sat, in_bri;
  logic [HB+IW-1:0]  hue_ext;
  logic [HB-1:0]     h;
  logic [HB+2:0]     h6;
  logic [CW-1:0]     sat_ext;

  hsv2rgb_pkg::sector_e sec1_q;
  logic [HB-1:0]     f1_q;
  logic [FW-1:0]     s1_q;
  logic [IW-1:0]     v1_q;

  assign in_hue  = s_axis_tdata_i[15:0];
  assign in_sat  = s_axis_tdata_i[31:16];
  assign in_bri  = s_axis_tdata_i[47:32];
  assign hue_ext = {HB'(0), in_hue};
  assign h       = hue_ext[HB-1:0];
  assign h6      = {1'b0, h, 2'b00} + {2'b00, h, 1'b0};
  assign sat_ext = CW'(in_sat);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec1_q <= hsv2rgb_pkg::sector_e'(h6[HB+2:HB]);
      f1_q   <= h6[HB-1:0];
      s1_q   <= (sat_ext > ONE_C) ? ONE_F : sat_ext[FW-1:0];
      v1_q   <= in_bri;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: f*S and (1-f)*S, floored to FRAC_BITS
  logic [HB:0]       omf;
  logic [HB+FW-1:0]  fs_prod;
  logic [HB+FW:0]    ts_prod;

  hsv2rgb_pkg::sector_e sec2_q;
  logic [FW-1:0]     qs2_q, ts2_q, s2_q;
  logic [IW-1:0]     v2_q;

  assign omf     = ONE_H - {1'b0, f1_q};
  assign fs_prod = f1_q * s1_q;
  assign ts_prod = omf * s1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec2_q <= sec1_q;
      qs2_q  <= fs_prod[HB+FW-1:HB];
      ts2_q  <= ts_prod[HB+FW-1:HB];
      s2_q   <= s1_q;
      v2_q   <= v1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: p, q, t and the sector select
  logic [FW-1:0] fp, fq, ft;
  logic [FW-1:0] fr, fg, fb;
  logic [FW-1:0] fr3_q, fg3_q, fb3_q;
  logic [IW-1:0] v3_q;

  assign fp = ONE_F - s2_q;
  assign fq = ONE_F - qs2_q;
  assign ft = ONE_F - ts2_q;

  always_comb begin
    unique case (sec2_q)
      hsv2rgb_pkg::SEC_0: begin fr = ONE_F; fg = ft;    fb = fp;    end
      hsv2rgb_pkg::SEC_1: begin fr = fq;    fg = ONE_F; fb = fp;    end
      hsv2rgb_pkg::SEC_2: begin fr = fp;    fg = ONE_F; fb = ft;    end
      hsv2rgb_pkg::SEC_3: begin fr = fp;    fg = fq;    fb = ONE_F; end
      hsv2rgb_pkg::SEC_4: begin fr = ft;    fg = fp;    fb = ONE_F; end
      hsv2rgb_pkg::SEC_5: begin fr = ONE_F; fg = fp;    fb = fq;    end
      default:            begin fr = ONE_F; fg = fp;    fb = fq;    end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fr3_q <= fr;
      fg3_q <= fg;
      fb3_q <= fb;
      v3_q  <= v2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: value times level
  logic [LW-1:0] lr4_q, lg4_q, lb4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lr4_q <= v3_q * fr3_q;
      lg4_q <= v3_q * fg3_q;
      lb4_q <= v3_q * fb3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: times channel scale
  logic [PW-1:0] pr5_q, pg5_q, pb5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr5_q <= lr4_q * scale_red_q;
      pg5_q <= lg4_q * scale_green_q;
      pb5_q <= lb4_q * scale_blue_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: drop 2*FRAC_BITS fraction bits, clamp at 100
  logic [EW-1:0] dr, dg, db;
  logic [DW-1:0] red_q, green_q, blue_q;

  assign dr = EW'(pr5_q) >> (2 * FRAC_BITS);
  assign dg = EW'(pg5_q) >> (2 * FRAC_BITS);
  assign db = EW'(pb5_q) >> (2 * FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= (dr > MAX_E) ? hsv2rgb_pkg::DUTY_MAX : dr[DW-1:0];
      green_q <= (dg > MAX_E) ? hsv2rgb_pkg::DUTY_MAX : dg[DW-1:0];
      blue_q  <= (db > MAX_E) ? hsv2rgb_pkg::DUTY_MAX : db[DW-1:0];
    end
  end

  assign m_axis_tdata_o = {3'b000, blue_q, green_q, red_q};

endmodule

>>> rtl/hsv2rgb_checker.sv
// Port-level checks for the HSV to RGB duty converter, bound to the top level.
// Depends on hsv2rgb_pkg and hsv_to_rgb_duty_converter.
module hsv2rgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [31:0] prdata
);

  // held output word must not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  // every duty stays within 0..100
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[6:0]   <= hsv2rgb_pkg::DUTY_MAX &&
      m_axis_tdata_o[13:7]  <= hsv2rgb_pkg::DUTY_MAX &&
      m_axis_tdata_o[20:14] <= hsv2rgb_pkg::DUTY_MAX &&
      m_axis_tdata_o[23:21] == 3'b000)
    else $error("duty out of range");

  // input side moves exactly when the output register frees up
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready out of step with output");

  // scale registers are 7 bits wide
  a_prdata_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:7] == 25'd0)
    else $error("read data upper bits set");

endmodule

bind hsv_to_rgb_duty_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .prdata          (prdata)
);
